// File: rtl/fsmc_pkg.sv
// Shared types and constants for the flash save-memory controller.
// No dependencies; the other files, apart from fsmc_ram, refer to this package by scoped names.
package fsmc_pkg;

  localparam int PAGES       = 1024;
  localparam int PAGE_WORDS  = 32;
  localparam int STORE_WORDS = PAGES * PAGE_WORDS;
  localparam int PAGE_W      = $clog2(PAGES);
  localparam int WORD_W      = $clog2(PAGE_WORDS);
  localparam int ADDR_W      = PAGE_W + WORD_W;
  localparam int SUM_W       = ((ADDR_W > 15) ? ADDR_W : 15) + 1;

  localparam int OP_W     = 2;
  localparam int DATA_W   = 32;
  localparam int OFFSET_W = 16;
  localparam int INDEX_W  = 6;

  typedef enum logic [OP_W-1:0] {
    OP_CMD    = 2'd0,
    OP_STATUS = 2'd1,
    OP_DMA_RD = 2'd2,
    OP_DMA_WR = 2'd3
  } op_t;

  typedef enum logic [2:0] {
    MODE_IDLE   = 3'd0,
    MODE_READ   = 3'd1,
    MODE_ERASE  = 3'd2,
    MODE_WRITE  = 3'd3,
    MODE_STATUS = 3'd4
  } mode_t;

  localparam logic [7:0] CMD_SET_PAGE   = 8'h4b;
  localparam logic [7:0] CMD_ERASE      = 8'h78;
  localparam logic [7:0] CMD_PAGE_STAT  = 8'ha5;
  localparam logic [7:0] CMD_WRITE      = 8'hb4;
  localparam logic [7:0] CMD_EXECUTE    = 8'hd2;
  localparam logic [7:0] CMD_STATUS     = 8'he1;
  localparam logic [7:0] CMD_READ       = 8'hf0;

  localparam logic [63:0] STAT_ERASE     = 64'h1111800800c20000;
  localparam logic [63:0] STAT_PAGE      = 64'h1111800400c20000;
  localparam logic [63:0] STAT_STATUS    = 64'h1111800100c20000;
  localparam logic [63:0] STAT_READ      = 64'h11118004f0000000;

  typedef enum logic [3:0] {
    S_CLEAR = 4'b0001,
    S_IDLE  = 4'b0010,
    S_EXEC  = 4'b0100,
    S_READ  = 4'b1000
  } state_t;

  typedef struct packed {
    logic accept;
    logic clear_step;
    logic exec_step;
    logic load_read;
  } ctrl_cmd_t;

  typedef struct packed {
    logic clear_last;
    logic exec_last;
    logic exec_start;
    logic store_read;
  } dp_sts_t;

endpackage

// File: rtl/fsmc_in_if.sv
// Input channel interface of the flash save-memory controller.
// Depends on fsmc_pkg for field widths.
interface fsmc_in_if;
  logic                          valid;
  logic                          ready;
  logic [fsmc_pkg::OP_W-1:0]     op;
  logic [fsmc_pkg::DATA_W-1:0]   bus_word;
  logic [fsmc_pkg::OFFSET_W-1:0] dma_offset;
  logic [fsmc_pkg::INDEX_W-1:0]  word_index;

  modport source (output valid, op, bus_word, dma_offset, word_index, input ready);
  modport sink (input valid, op, bus_word, dma_offset, word_index, output ready);
endinterface

// File: rtl/fsmc_out_if.sv
// Result channel interface of the flash save-memory controller.
// Depends on fsmc_pkg for field widths.
interface fsmc_out_if;
  logic                        valid;
  logic                        ready;
  logic [fsmc_pkg::DATA_W-1:0] read_data;
  logic                        error;

  modport source (output valid, read_data, error, input ready);
  modport sink (input valid, read_data, error, output ready);
endinterface

// File: rtl/flash_save_memory_controller.sv
// Flash save-memory controller: one result transaction per input transaction.
// Command, status read, status DMA read and DMA write results are registered
// straight into the result register; a store DMA read passes first through the
// registered read of the store RAM. An execute in erase or write mode returns
// its result at once and then writes the page through the store's single write
// port, one word a cycle, so input stalls until all PAGE_WORDS (32) words are
// written. After reset the store is filled with all ones, one word a cycle, and
// no input transaction is accepted until all STORE_WORDS (32768) are written.
// Depends on fsmc_pkg, fsmc_in_if, fsmc_out_if, fsmc_ctrl and fsmc_dp.
module flash_save_memory_controller (
  input logic      clk,
  input logic      rst_n,
  fsmc_in_if.sink  in_ch,
  fsmc_out_if.source out_ch
);

  fsmc_pkg::ctrl_cmd_t cmd;
  fsmc_pkg::dp_sts_t   sts;

  fsmc_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_ch.valid),
    .in_ready  (in_ch.ready),
    .out_valid (out_ch.valid),
    .out_ready (out_ch.ready),
    .cmd       (cmd),
    .sts       (sts)
  );

  fsmc_dp u_dp (
    .clk           (clk),
    .rst_n         (rst_n),
    .cmd           (cmd),
    .sts           (sts),
    .in_op         (in_ch.op),
    .in_bus_word   (in_ch.bus_word),
    .in_dma_offset (in_ch.dma_offset),
    .in_word_index (in_ch.word_index),
    .out_read_data (out_ch.read_data),
    .out_error     (out_ch.error)
  );

endmodule

// File: rtl/fsmc_ram.sv
// Generic simple dual-port RAM with one write port and a registered read port.
// No dependencies.
module fsmc_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 1024
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// File: rtl/fsmc_dp.sv
// Datapath of the flash save-memory controller: mode, status, page, page
// buffer, flash store and result register. Depends on fsmc_pkg and fsmc_ram.
module fsmc_dp (
  input  logic                          clk,
  input  logic                          rst_n,
  input  fsmc_pkg::ctrl_cmd_t           cmd,
  output fsmc_pkg::dp_sts_t             sts,
  input  logic [fsmc_pkg::OP_W-1:0]     in_op,
  input  logic [fsmc_pkg::DATA_W-1:0]   in_bus_word,
  input  logic [fsmc_pkg::OFFSET_W-1:0] in_dma_offset,
  input  logic [fsmc_pkg::INDEX_W-1:0]  in_word_index,
  output logic [fsmc_pkg::DATA_W-1:0]   out_read_data,
  output logic                          out_error
);

  fsmc_pkg::mode_t                    mode_r, mode_nxt;
  logic [63:0]                        status_r, status_nxt;
  logic [fsmc_pkg::PAGE_W-1:0]        page_r, page_nxt;
  logic [fsmc_pkg::DATA_W-1:0]        buf_r [fsmc_pkg::PAGE_WORDS];
  logic [fsmc_pkg::ADDR_W-1:0]        seq_cnt_r, seq_cnt_nxt;
  logic                               erase_r, erase_nxt;
  logic [fsmc_pkg::DATA_W-1:0]        data_r, data_nxt;
  logic                               error_r, error_nxt;

  fsmc_pkg::op_t                      op;
  logic [7:0]                         opcode;
  logic [fsmc_pkg::DATA_W-1:0]        imm_data;
  logic                               imm_error;
  logic                               buf_we;
  logic [fsmc_pkg::SUM_W-1:0]         rd_sum;
  logic                               ram_we;
  logic [fsmc_pkg::ADDR_W-1:0]        ram_waddr;
  logic [fsmc_pkg::DATA_W-1:0]        ram_wdata;
  logic [fsmc_pkg::DATA_W-1:0]        ram_rdata;
  logic [fsmc_pkg::WORD_W-1:0]        seq_word;

  assign op       = fsmc_pkg::op_t'(in_op);
  assign opcode   = in_bus_word[31:24];
  assign seq_word = seq_cnt_r[fsmc_pkg::WORD_W-1:0];
  assign rd_sum   = fsmc_pkg::SUM_W'(in_dma_offset[15:1]) + fsmc_pkg::SUM_W'(in_word_index);

  assign sts.clear_last = (seq_cnt_r == {fsmc_pkg::ADDR_W{1'b1}});
  assign sts.exec_last  = (seq_word == {fsmc_pkg::WORD_W{1'b1}});
  assign sts.store_read = (op == fsmc_pkg::OP_DMA_RD) && (mode_r == fsmc_pkg::MODE_READ);
  assign sts.exec_start = (op == fsmc_pkg::OP_CMD) && (opcode == fsmc_pkg::CMD_EXECUTE) &&
                          ((mode_r == fsmc_pkg::MODE_ERASE) ||
                           (mode_r == fsmc_pkg::MODE_WRITE));

  always_comb begin
    mode_nxt   = mode_r;
    status_nxt = status_r;
    page_nxt   = page_r;
    imm_data   = '0;
    imm_error  = 1'b0;
    buf_we     = 1'b0;
    case (op)
      fsmc_pkg::OP_CMD: begin
        case (opcode)
          fsmc_pkg::CMD_SET_PAGE: begin
            page_nxt = in_bus_word[fsmc_pkg::PAGE_W-1:0];
          end
          fsmc_pkg::CMD_ERASE: begin
            mode_nxt   = fsmc_pkg::MODE_ERASE;
            status_nxt = fsmc_pkg::STAT_ERASE;
          end
          fsmc_pkg::CMD_PAGE_STAT: begin
            page_nxt   = in_bus_word[fsmc_pkg::PAGE_W-1:0];
            status_nxt = fsmc_pkg::STAT_PAGE;
          end
          fsmc_pkg::CMD_WRITE: begin
            mode_nxt = fsmc_pkg::MODE_WRITE;
          end
          fsmc_pkg::CMD_EXECUTE: begin
            mode_nxt = fsmc_pkg::MODE_IDLE;
          end
          fsmc_pkg::CMD_STATUS: begin
            mode_nxt   = fsmc_pkg::MODE_STATUS;
            status_nxt = fsmc_pkg::STAT_STATUS;
          end
          fsmc_pkg::CMD_READ: begin
            mode_nxt   = fsmc_pkg::MODE_READ;
            status_nxt = fsmc_pkg::STAT_READ;
          end
          default: begin
            imm_error = 1'b1;
          end
        endcase
      end
      fsmc_pkg::OP_STATUS: begin
        imm_data = status_r[63:32];
      end
      fsmc_pkg::OP_DMA_RD: begin
        if (mode_r == fsmc_pkg::MODE_STATUS) begin
          imm_data = in_word_index[0] ? status_r[31:0] : status_r[63:32];
        end else if (mode_r != fsmc_pkg::MODE_READ) begin
          imm_error = 1'b1;
        end
      end
      fsmc_pkg::OP_DMA_WR: begin
        if (mode_r == fsmc_pkg::MODE_WRITE) begin
          buf_we = 1'b1;
        end else begin
          imm_error = 1'b1;
        end
      end
      default: begin
        imm_error = 1'b1;
      end
    endcase
  end

  always_comb begin
    seq_cnt_nxt = seq_cnt_r;
    erase_nxt   = erase_r;
    if (cmd.accept && sts.exec_start) begin
      seq_cnt_nxt = '0;
      erase_nxt   = (mode_r == fsmc_pkg::MODE_ERASE);
    end else if (cmd.clear_step || cmd.exec_step) begin
      seq_cnt_nxt = seq_cnt_r + 1'b1;
    end
  end

  always_comb begin
    data_nxt  = data_r;
    error_nxt = error_r;
    if (cmd.accept) begin
      data_nxt  = imm_data;
      error_nxt = imm_error;
    end else if (cmd.load_read) begin
      data_nxt  = ram_rdata;
      error_nxt = 1'b0;
    end
  end

  assign ram_we    = cmd.clear_step || cmd.exec_step;
  assign ram_waddr = cmd.clear_step ? seq_cnt_r : {page_r, seq_word};
  assign ram_wdata = (cmd.clear_step || erase_r) ? {fsmc_pkg::DATA_W{1'b1}} : buf_r[seq_word];

  fsmc_ram #(
    .WIDTH(fsmc_pkg::DATA_W),
    .DEPTH(fsmc_pkg::STORE_WORDS)
  ) u_store (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .re    (cmd.accept && sts.store_read),
    .raddr (rd_sum[fsmc_pkg::ADDR_W-1:0]),
    .rdata (ram_rdata)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r    <= fsmc_pkg::MODE_IDLE;
      status_r  <= '0;
      page_r    <= '0;
      seq_cnt_r <= '0;
      erase_r   <= 1'b0;
      for (int i = 0; i < fsmc_pkg::PAGE_WORDS; i++) begin
        buf_r[i] <= '0;
      end
    end else begin
      seq_cnt_r <= seq_cnt_nxt;
      erase_r   <= erase_nxt;
      if (cmd.accept) begin
        mode_r   <= mode_nxt;
        status_r <= status_nxt;
        page_r   <= page_nxt;
        if (buf_we) begin
          buf_r[in_word_index[fsmc_pkg::WORD_W-1:0]] <= in_bus_word;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    data_r  <= data_nxt;
    error_r <= error_nxt;
  end

  assign out_read_data = data_r;
  assign out_error     = error_r;

endmodule

// File: rtl/fsmc_ctrl.sv
// Controller of the flash save-memory controller: store clearing after reset,
// page execute sequencing, store read wait and result handshake. Uses fsmc_pkg.
module fsmc_ctrl (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_ready,
  output logic                out_valid,
  input  logic                out_ready,
  output fsmc_pkg::ctrl_cmd_t cmd,
  input  fsmc_pkg::dp_sts_t   sts
);

  fsmc_pkg::state_t state_r, state_nxt;
  logic             out_valid_r, out_valid_nxt;
  logic             accept;

  assign in_ready = (state_r == fsmc_pkg::S_IDLE) && (!out_valid_r || out_ready);
  assign accept   = in_valid && in_ready;

  assign cmd.accept     = accept;
  assign cmd.clear_step = (state_r == fsmc_pkg::S_CLEAR);
  assign cmd.exec_step  = (state_r == fsmc_pkg::S_EXEC);
  assign cmd.load_read  = (state_r == fsmc_pkg::S_READ);

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      fsmc_pkg::S_CLEAR: begin
        if (sts.clear_last) begin
          state_nxt = fsmc_pkg::S_IDLE;
        end
      end
      fsmc_pkg::S_IDLE: begin
        if (accept && sts.store_read) begin
          state_nxt = fsmc_pkg::S_READ;
        end else if (accept && sts.exec_start) begin
          state_nxt = fsmc_pkg::S_EXEC;
        end
      end
      fsmc_pkg::S_EXEC: begin
        if (sts.exec_last) begin
          state_nxt = fsmc_pkg::S_IDLE;
        end
      end
      fsmc_pkg::S_READ: begin
        state_nxt = fsmc_pkg::S_IDLE;
      end
      default: begin
        state_nxt = fsmc_pkg::S_IDLE;
      end
    endcase
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (out_valid_r && out_ready) begin
      out_valid_nxt = 1'b0;
    end
    if ((accept && !sts.store_read) || (state_r == fsmc_pkg::S_READ)) begin
      out_valid_nxt = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= fsmc_pkg::S_CLEAR;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  assign out_valid = out_valid_r;

  a_state_onehot: assert property (@(posedge clk) disable iff (!rst_n)
    $onehot(state_r)) else $error("controller state is not one-hot");

  a_read_slot_free: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == fsmc_pkg::S_READ) |-> !out_valid_r)
    else $error("store read data would overwrite a pending result");

  a_read_wait: assert property (@(posedge clk) disable iff (!rst_n)
    (accept && sts.store_read) |=> (state_r == fsmc_pkg::S_READ) && !out_valid_r)
    else $error("store read did not enter the read wait state");

  a_exec_end: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == fsmc_pkg::S_EXEC && sts.exec_last) |=> (state_r == fsmc_pkg::S_IDLE))
    else $error("page execute did not end after the last word");

endmodule

// File: tb/fsmc_access_check.sv
`timescale 1ns / 1ps
// Watches the access and result channels of the flash save-memory controller,
// predicts each result from its own copy of the controller state and compares.
// Depends on fsmc_pkg, fsmc_in_if and fsmc_out_if.
module fsmc_access_check (
  input  logic clk,
  input  logic rst_n,
  fsmc_in_if   in_ch,
  fsmc_out_if  out_ch,
  output int   failures,
  output int   outstanding
);

  typedef struct packed {
    logic [fsmc_pkg::DATA_W-1:0] read_data;
    logic                        error;
  } reply_t;

  fsmc_pkg::mode_t             cur_mode;
  logic [63:0]                 status_word;
  logic [fsmc_pkg::PAGE_W-1:0] page_sel;
  logic [fsmc_pkg::DATA_W-1:0] page_buf [fsmc_pkg::PAGE_WORDS];
  logic [fsmc_pkg::DATA_W-1:0] store_mem [fsmc_pkg::STORE_WORDS];
  reply_t                      reply_q [$];
  reply_t                      want;

  function automatic reply_t flash_access(fsmc_pkg::op_t op,
                                          logic [fsmc_pkg::DATA_W-1:0] word,
                                          logic [fsmc_pkg::OFFSET_W-1:0] offs,
                                          logic [fsmc_pkg::INDEX_W-1:0] idx);
    reply_t                      r;
    logic [fsmc_pkg::ADDR_W-1:0] addr;
    r = '0;
    case (op)
      fsmc_pkg::OP_CMD: begin
        case (word[31:24])
          fsmc_pkg::CMD_SET_PAGE: page_sel = word[fsmc_pkg::PAGE_W-1:0];
          fsmc_pkg::CMD_ERASE: begin
            cur_mode = fsmc_pkg::MODE_ERASE;
            status_word = fsmc_pkg::STAT_ERASE;
          end
          fsmc_pkg::CMD_PAGE_STAT: begin
            page_sel = word[fsmc_pkg::PAGE_W-1:0];
            status_word = fsmc_pkg::STAT_PAGE;
          end
          fsmc_pkg::CMD_WRITE: cur_mode = fsmc_pkg::MODE_WRITE;
          fsmc_pkg::CMD_EXECUTE: begin
            for (int k = 0; k < fsmc_pkg::PAGE_WORDS; k++) begin
              if (cur_mode == fsmc_pkg::MODE_ERASE) begin
                store_mem[{page_sel, k[fsmc_pkg::WORD_W-1:0]}] = '1;
              end else if (cur_mode == fsmc_pkg::MODE_WRITE) begin
                store_mem[{page_sel, k[fsmc_pkg::WORD_W-1:0]}] = page_buf[k];
              end
            end
            cur_mode = fsmc_pkg::MODE_IDLE;
          end
          fsmc_pkg::CMD_STATUS: begin
            cur_mode = fsmc_pkg::MODE_STATUS;
            status_word = fsmc_pkg::STAT_STATUS;
          end
          fsmc_pkg::CMD_READ: begin
            cur_mode = fsmc_pkg::MODE_READ;
            status_word = fsmc_pkg::STAT_READ;
          end
          default: r.error = 1'b1;
        endcase
      end
      fsmc_pkg::OP_STATUS: r.read_data = status_word[63:32];
      fsmc_pkg::OP_DMA_RD: begin
        if (cur_mode == fsmc_pkg::MODE_STATUS) begin
          r.read_data = idx[0] ? status_word[31:0] : status_word[63:32];
        end else if (cur_mode == fsmc_pkg::MODE_READ) begin
          // The start offset counts halfwords; the store address rounds down to a word.
          addr = fsmc_pkg::ADDR_W'(offs >> 1) + fsmc_pkg::ADDR_W'(idx);
          r.read_data = store_mem[addr];
        end else begin
          r.error = 1'b1;
        end
      end
      default: begin
        if (cur_mode == fsmc_pkg::MODE_WRITE) begin
          page_buf[idx[fsmc_pkg::WORD_W-1:0]] = word;
        end else begin
          r.error = 1'b1;
        end
      end
    endcase
    return r;
  endfunction

  always @(posedge clk) begin
    if (!rst_n) begin
      cur_mode = fsmc_pkg::MODE_IDLE;
      status_word = '0;
      page_sel = '0;
      for (int k = 0; k < fsmc_pkg::PAGE_WORDS; k++) page_buf[k] = '0;
      for (int k = 0; k < fsmc_pkg::STORE_WORDS; k++) store_mem[k] = '1;
      reply_q.delete();
      failures = 0;
      outstanding = 0;
    end else begin
      if (in_ch.valid && in_ch.ready) begin
        reply_q.push_back(flash_access(fsmc_pkg::op_t'(in_ch.op), in_ch.bus_word,
                                       in_ch.dma_offset, in_ch.word_index));
      end
      if (out_ch.valid && out_ch.ready) begin
        if (reply_q.size() == 0) begin
          $error("Result transaction with no access outstanding: read_data %h, error %b",
                 out_ch.read_data, out_ch.error);
          failures++;
        end else begin
          want = reply_q.pop_front();
          if (out_ch.read_data !== want.read_data) begin
            $error("read_data mismatch: expected %h, actual %h", want.read_data,
                   out_ch.read_data);
            failures++;
          end
          if (out_ch.error !== want.error) begin
            $error("error mismatch: expected %b, actual %b", want.error, out_ch.error);
            failures++;
          end
        end
      end
      outstanding = reply_q.size();
    end
  end

endmodule

// File: tb/tb_flash_save_memory_controller.sv
`timescale 1ns / 1ps
// Top of the flash save-memory controller testbench: clock, reset, access
// stimulus, result back-pressure, watchdog and verdict.
// Depends on fsmc_pkg, fsmc_in_if, fsmc_out_if, fsmc_access_check and the block.
module tb_flash_save_memory_controller;

  localparam int RANDOM_ACCESSES = 400;
  localparam int IDLE_LIMIT      = 100000;

  logic                        clk;
  logic                        rst_n;
  int                          failures;
  int                          outstanding;
  int                          idle_cycles = 0;
  int                          burst_left = 0;
  int                          accesses_sent = 0;
  logic [fsmc_pkg::PAGE_W-1:0] hot_pages [4];

  fsmc_in_if  in_ch ();
  fsmc_out_if out_ch ();

  flash_save_memory_controller DUT (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch)
  );

  fsmc_access_check access_check (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_ch       (in_ch),
    .out_ch      (out_ch),
    .failures    (failures),
    .outstanding (outstanding)
  );

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  always @(posedge clk) begin
    if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= IDLE_LIMIT) begin
      $display("FAIL flash_save_memory_controller");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  // Result side: mostly ready, with short stalls and occasional long calm stretches.
  initial begin
    int hold;
    int calm;
    hold = 0;
    calm = 0;
    out_ch.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (calm > 0) begin
        out_ch.ready <= 1'b1;
        calm--;
      end else if (hold > 0) begin
        out_ch.ready <= 1'b0;
        hold--;
      end else begin
        out_ch.ready <= 1'b1;
        case ($urandom_range(0, 19))
          0: calm = $urandom_range(20, 120);
          1, 2, 3, 4: hold = $urandom_range(1, 8);
          default: ;
        endcase
      end
    end
  end

  task automatic send(fsmc_pkg::op_t op, logic [fsmc_pkg::DATA_W-1:0] word,
                      logic [fsmc_pkg::OFFSET_W-1:0] offs,
                      logic [fsmc_pkg::INDEX_W-1:0] idx);
    if (burst_left <= 0) begin
      in_ch.valid <= 1'b0;
      repeat ($urandom_range(1, 6)) @(posedge clk);
      burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(30, 90) : $urandom_range(1, 12);
    end
    in_ch.valid      <= 1'b1;
    in_ch.op         <= op;
    in_ch.bus_word   <= word;
    in_ch.dma_offset <= offs;
    in_ch.word_index <= idx;
    do @(posedge clk); while (!in_ch.ready);
    burst_left--;
    accesses_sent++;
  endtask

  task automatic command(logic [7:0] code, logic [15:0] low);
    send(fsmc_pkg::OP_CMD, {code, 8'($urandom), low}, 16'($urandom), 6'($urandom));
  endtask

  // Holds the access side off until every result transaction has come back.
  task automatic drain();
    in_ch.valid <= 1'b0;
    burst_left = 0;
    do @(posedge clk); while (outstanding != 0);
  endtask

  function automatic logic [15:0] page_field(logic [fsmc_pkg::PAGE_W-1:0] page);
    logic [15:0] f;
    f = 16'($urandom);
    f[fsmc_pkg::PAGE_W-1:0] = page;
    return f;
  endfunction

  initial begin
    logic [fsmc_pkg::PAGE_W-1:0] page;
    int                          directed_count;
    rst_n            <= 1'b0;
    in_ch.valid      <= 1'b0;
    in_ch.op         <= fsmc_pkg::OP_CMD;
    in_ch.bus_word   <= '0;
    in_ch.dma_offset <= '0;
    in_ch.word_index <= '0;
    hot_pages[0] = '0;
    hot_pages[1] = '1;
    hot_pages[2] = fsmc_pkg::PAGE_W'($urandom);
    hot_pages[3] = fsmc_pkg::PAGE_W'($urandom);
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;

    send(fsmc_pkg::OP_STATUS, 32'h0, 16'h0, 6'd0);
    send(fsmc_pkg::OP_DMA_RD, 32'h0, 16'hffff, 6'd63);
    send(fsmc_pkg::OP_DMA_WR, 32'hffffffff, 16'h0, 6'd63);
    send(fsmc_pkg::OP_CMD, 32'h00000000, 16'h0, 6'd0);
    send(fsmc_pkg::OP_CMD, 32'hffffffff, 16'hffff, 6'd63);
    send(fsmc_pkg::OP_CMD, {fsmc_pkg::CMD_EXECUTE, 24'h0}, 16'h0, 6'd0);
    send(fsmc_pkg::OP_CMD, {fsmc_pkg::CMD_READ, 24'h0}, 16'h0, 6'd0);
    send(fsmc_pkg::OP_DMA_RD, 32'h0, 16'hffff, 6'd63);
    send(fsmc_pkg::OP_DMA_RD, 32'h0, 16'h0001, 6'd0);
    send(fsmc_pkg::OP_CMD, {fsmc_pkg::CMD_STATUS, 24'hffffff}, 16'h0, 6'd0);
    send(fsmc_pkg::OP_DMA_RD, 32'h0, 16'h0, 6'd0);
    send(fsmc_pkg::OP_DMA_RD, 32'h0, 16'h0, 6'd1);
    send(fsmc_pkg::OP_STATUS, 32'h0, 16'h0, 6'd0);
    send(fsmc_pkg::OP_CMD, {fsmc_pkg::CMD_EXECUTE, 24'h0}, 16'h0, 6'd0);
    send(fsmc_pkg::OP_CMD, {fsmc_pkg::CMD_PAGE_STAT, 8'h00, 16'hffff}, 16'h0, 6'd0);
    send(fsmc_pkg::OP_CMD, {fsmc_pkg::CMD_WRITE, 24'h0}, 16'h0, 6'd0);
    send(fsmc_pkg::OP_DMA_WR, 32'h00000000, 16'h0, 6'd0);
    send(fsmc_pkg::OP_DMA_WR, 32'hffffffff, 16'h0, 6'd63);
    send(fsmc_pkg::OP_DMA_WR, 32'ha5a5a5a5, 16'h0, 6'd32);
    send(fsmc_pkg::OP_CMD, {fsmc_pkg::CMD_EXECUTE, 24'h0}, 16'h0, 6'd0);
    send(fsmc_pkg::OP_CMD, {fsmc_pkg::CMD_READ, 24'h0}, 16'h0, 6'd0);
    send(fsmc_pkg::OP_DMA_RD, 32'h0, 16'hffc0, 6'd0);
    send(fsmc_pkg::OP_DMA_RD, 32'h0, 16'hffc1, 6'd31);
    send(fsmc_pkg::OP_CMD, {fsmc_pkg::CMD_EXECUTE, 24'h0}, 16'h0, 6'd0);
    send(fsmc_pkg::OP_CMD, {fsmc_pkg::CMD_SET_PAGE, 8'h00, 16'h07ff}, 16'h0, 6'd0);
    send(fsmc_pkg::OP_CMD, {fsmc_pkg::CMD_ERASE, 24'h0}, 16'h0, 6'd0);
    send(fsmc_pkg::OP_CMD, {fsmc_pkg::CMD_EXECUTE, 24'h0}, 16'h0, 6'd0);
    drain();
    directed_count = accesses_sent;

    while (accesses_sent < directed_count + RANDOM_ACCESSES) begin
      page = ($urandom_range(0, 3) == 0) ? fsmc_pkg::PAGE_W'($urandom)
                                         : hot_pages[$urandom_range(0, 3)];
      case ($urandom_range(0, 9))
        0, 1, 2: begin
          if ($urandom_range(0, 1) == 0) command(fsmc_pkg::CMD_SET_PAGE, page_field(page));
          else command(fsmc_pkg::CMD_PAGE_STAT, page_field(page));
          command(fsmc_pkg::CMD_WRITE, 16'($urandom));
          repeat ($urandom_range(1, 40)) begin
            if ($urandom_range(0, 15) == 0) begin
              send(fsmc_pkg::OP_STATUS, $urandom, 16'($urandom), 6'($urandom));
            end else begin
              send(fsmc_pkg::OP_DMA_WR, $urandom, 16'($urandom), 6'($urandom));
            end
          end
          command(fsmc_pkg::CMD_EXECUTE, 16'($urandom));
        end
        3: begin
          command(fsmc_pkg::CMD_ERASE, 16'($urandom));
          if ($urandom_range(0, 1) == 0) command(fsmc_pkg::CMD_PAGE_STAT, page_field(page));
          else command(fsmc_pkg::CMD_SET_PAGE, page_field(page));
          command(fsmc_pkg::CMD_EXECUTE, 16'($urandom));
        end
        4, 5: begin
          command(fsmc_pkg::CMD_READ, 16'($urandom));
          repeat ($urandom_range(1, 24)) begin
            send(fsmc_pkg::OP_DMA_RD, $urandom,
                 ($urandom_range(0, 3) == 0) ? 16'($urandom) : {page, 6'($urandom)},
                 6'($urandom));
          end
        end
        6: begin
          if ($urandom_range(0, 1) == 0) command(fsmc_pkg::CMD_STATUS, 16'($urandom));
          else command(fsmc_pkg::CMD_READ, 16'($urandom));
          repeat ($urandom_range(1, 8)) begin
            if ($urandom_range(0, 2) == 0) begin
              send(fsmc_pkg::OP_STATUS, $urandom, 16'($urandom), 6'($urandom));
            end else begin
              send(fsmc_pkg::OP_DMA_RD, $urandom, 16'($urandom), 6'($urandom));
            end
          end
          if ($urandom_range(0, 2) == 0) command(fsmc_pkg::CMD_EXECUTE, 16'($urandom));
        end
        7, 8: begin
          repeat ($urandom_range(1, 4)) begin
            send(fsmc_pkg::op_t'($urandom_range(0, 3)), $urandom, 16'($urandom),
                 6'($urandom));
          end
        end
        default: begin
          case ($urandom_range(0, 3))
            0: command(fsmc_pkg::CMD_ERASE, 16'($urandom));
            1: command(fsmc_pkg::CMD_WRITE, 16'($urandom));
            2: command(fsmc_pkg::CMD_READ, 16'($urandom));
            default: command(fsmc_pkg::CMD_STATUS, 16'($urandom));
          endcase
          repeat ($urandom_range(1, 6)) begin
            send(fsmc_pkg::op_t'($urandom_range(0, 3)), $urandom, 16'($urandom),
                 6'($urandom));
          end
        end
      endcase
      if ($urandom_range(0, 11) == 0) drain();
    end

    drain();
    repeat (2 * fsmc_pkg::PAGE_WORDS) @(posedge clk);
    if (failures == 0) begin
      $display("PASS flash_save_memory_controller");
    end else begin
      $display("FAIL flash_save_memory_controller");
    end
    $finish;
  end

endmodule
